@@ rtl/core/irpdt_pkg.sv @@
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants of the pulse-distance infrared transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned MARK_W      = 10;
  localparam int unsigned SPACE_W     = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_Q8 = 16'd2560;

  localparam logic [PERIOD_W-1:0] RST_CARRIER_PERIOD = 16'd6733;
  localparam logic [MARK_W-1:0]   RST_START_MARK     = 10'd129;
  localparam logic [MARK_W-1:0]   RST_BIT_MARK       = 10'd18;
  localparam logic [SPACE_W-1:0]  RST_START_SPACE    = 16'd1736;
  localparam logic [SPACE_W-1:0]  RST_ONE_SPACE      = 16'd1210;
  localparam logic [SPACE_W-1:0]  RST_ZERO_SPACE     = 16'd395;
  localparam logic [SPACE_W-1:0]  RST_END_SPACE      = 16'd13992;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SYMBOL = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CARRIER_PERIOD = 3'd0,
    REG_START_MARK     = 3'd1,
    REG_BIT_MARK       = 3'd2,
    REG_START_SPACE    = 3'd3,
    REG_ONE_SPACE      = 3'd4,
    REG_ZERO_SPACE     = 3'd5,
    REG_END_SPACE      = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_ONE   = 2'd1,
    SYM_ZERO  = 2'd2,
    SYM_END   = 2'd3
  } symbol_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_SPACE = 2'd2
  } tx_mode_t;

  typedef struct packed {
    logic       command;
    logic [1:0] symbol;
  } item_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic rejected;
  } result_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] carrier_period_q8;
    logic [MARK_W-1:0]   start_mark_cycles;
    logic [MARK_W-1:0]   bit_mark_cycles;
    logic [SPACE_W-1:0]  start_space_us;
    logic [SPACE_W-1:0]  one_space_us;
    logic [SPACE_W-1:0]  zero_space_us;
    logic [SPACE_W-1:0]  end_space_us;
  } cfg_t;

  // One classified word on its way from front to back.
  typedef struct packed {
    logic               is_symbol;
    logic [MARK_W-1:0]  marks;
    logic [SPACE_W-1:0] space;
  } qentry_t;

endpackage

@@ rtl/core/ir_pulse_distance_transmitter_unit.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_unit
// Pulse-distance infrared transmitter with a decoupled front and back.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: each word is a one-microsecond tick (command 0) or a symbol
//   (command 1; start, one, zero, end). A symbol sends a carrier mark of the
//   configured cycle count, then a silent space of the configured length.
//   res channel: exactly one word per item, in order: emitter level, busy and
//   a rejected flag for a symbol offered while a mark or space still runs.
//   cfg channel: register writes by index, always ready; write only while
//   the block has no word in flight.
// Timing: an accepted item enters the two-entry queue on its accepting edge
//   and its result is registered when the back pops it from the queue. One
//   item per cycle is sustained while res_stall is low; the back updates
//   the phase accumulator and counters once per word.
// Stall: a stalled result holds in the output register; the back stops
//   popping, the queue fills, and item_stall rises once both slots are taken.
// Reset: returns all configuration registers to their defaults, empties the
//   queue and leaves the transmitter idle with no result valid.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_unit #(
  parameter int unsigned PHASE_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  irpdt_pkg::item_t                   item,
  input  logic                               item_valid,
  output logic                               item_stall,
  output irpdt_pkg::result_t                 res,
  output logic                               res_valid,
  input  logic                               res_stall,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [irpdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [irpdt_pkg::DATA_W-1:0]       cfg_data
);
  import irpdt_pkg::*;

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  qentry_t q_entry;
  logic    q_pop;
  logic    q_valid;
  qentry_t q_head;

  // Hold the software-set timing.
  irpdt_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Classify each word and look up its mark and space.
  irpdt_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Decouple front from back so either side can stall alone.
  irpdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Advance marks and spaces, one word per cycle while the result is not stalled.
  irpdt_back #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

@@ rtl/core/irpdt_regs.sv @@
// ----------------------------------------------------------------------------
// irpdt_regs
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
module irpdt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [irpdt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [irpdt_pkg::DATA_W-1:0]       cfg_data,
  output irpdt_pkg::cfg_t                    cfg
);
  import irpdt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_period_q8 <= RST_CARRIER_PERIOD;
      cfg.start_mark_cycles <= RST_START_MARK;
      cfg.bit_mark_cycles   <= RST_BIT_MARK;
      cfg.start_space_us    <= RST_START_SPACE;
      cfg.one_space_us      <= RST_ONE_SPACE;
      cfg.zero_space_us     <= RST_ZERO_SPACE;
      cfg.end_space_us      <= RST_END_SPACE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CARRIER_PERIOD: cfg.carrier_period_q8 <= cfg_data;
        REG_START_MARK:     cfg.start_mark_cycles <= cfg_data[MARK_W-1:0];
        REG_BIT_MARK:       cfg.bit_mark_cycles   <= cfg_data[MARK_W-1:0];
        REG_START_SPACE:    cfg.start_space_us    <= cfg_data;
        REG_ONE_SPACE:      cfg.one_space_us      <= cfg_data;
        REG_ZERO_SPACE:     cfg.zero_space_us     <= cfg_data;
        REG_END_SPACE:      cfg.end_space_us      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/irpdt_front.sv @@
// ----------------------------------------------------------------------------
// irpdt_front
// Accept words and classify them: tick or symbol with its mark and space.
// ----------------------------------------------------------------------------
module irpdt_front (
  input  irpdt_pkg::item_t   item,
  input  logic               item_valid,
  output logic               item_stall,
  input  irpdt_pkg::cfg_t    cfg,
  input  logic               q_full,
  output logic               q_push,
  output irpdt_pkg::qentry_t q_entry
);
  import irpdt_pkg::*;

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_entry.is_symbol = (item.command == CMD_SYMBOL);
    q_entry.marks     = '0;
    q_entry.space     = '0;
    if (item.command == CMD_SYMBOL) begin
      unique case (symbol_t'(item.symbol))
        SYM_START: begin
          q_entry.marks = cfg.start_mark_cycles;
          q_entry.space = cfg.start_space_us;
        end
        SYM_ONE: begin
          q_entry.marks = cfg.bit_mark_cycles;
          q_entry.space = cfg.one_space_us;
        end
        SYM_ZERO: begin
          q_entry.marks = cfg.bit_mark_cycles;
          q_entry.space = cfg.zero_space_us;
        end
        SYM_END: begin
          q_entry.marks = cfg.bit_mark_cycles;
          q_entry.space = cfg.end_space_us;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/irpdt_queue.sv @@
// ----------------------------------------------------------------------------
// irpdt_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module irpdt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  irpdt_pkg::qentry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output irpdt_pkg::qentry_t head
);
  import irpdt_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/irpdt_back.sv @@
// ----------------------------------------------------------------------------
// irpdt_back
// Run marks and spaces: phase accumulator, counters and the result register.
// ----------------------------------------------------------------------------
module irpdt_back #(
  parameter int unsigned PHASE_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  irpdt_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  irpdt_pkg::qentry_t q_head,
  output logic               q_pop,
  output irpdt_pkg::result_t res,
  output logic               res_valid,
  input  logic               res_stall
);
  import irpdt_pkg::*;

  localparam int unsigned PQ_W = PHASE_FRAC_BITS + 8;
  localparam int unsigned PA_W = PHASE_FRAC_BITS + 9;
  localparam logic [PA_W-1:0] PHASE_ONE  = PA_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PA_W-1:0] PHASE_HALF = PA_W'(1) << (PHASE_FRAC_BITS - 1);

  tx_mode_t           tx_mode, tx_mode_next;
  logic [PA_W-1:0]    phase_acc, phase_acc_next;
  logic [MARK_W-1:0]  marks_left, marks_left_next;
  logic [SPACE_W-1:0] space_left, space_left_next;
  logic [SPACE_W-1:0] pending_space, pending_space_next;
  result_t            res_next;

  logic [PERIOD_W-1:0]          period_clamped;
  logic [PERIOD_W+PHASE_FRAC_BITS-1:0] period_wide;
  logic [PQ_W-1:0]              period_q;
  logic [PA_W-1:0]              phase_sum;
  logic                         busy;
  logic                         accept_sym;
  logic                         wrap;
  logic [MARK_W-1:0]            marks_dec;
  logic [SPACE_W-1:0]           space_dec;

  assign q_pop = q_valid && (!res_valid || !res_stall);

  // Period in accumulator units, clamped to the shortest legal carrier.
  assign period_clamped = (cfg.carrier_period_q8 < MIN_PERIOD_Q8) ? MIN_PERIOD_Q8
                                                                 : cfg.carrier_period_q8;
  assign period_wide = {period_clamped, {PHASE_FRAC_BITS{1'b0}}};
  assign period_q    = period_wide[PERIOD_W+PHASE_FRAC_BITS-1:8];

  assign busy       = (tx_mode == MODE_MARK) || (tx_mode == MODE_SPACE);
  assign accept_sym = q_head.is_symbol && !busy;
  assign phase_sum  = phase_acc + PHASE_ONE;
  assign wrap       = (phase_sum >= {1'b0, period_q});
  assign marks_dec  = marks_left - 1'b1;
  assign space_dec  = space_left - 1'b1;

  // Next mode.
  always_comb begin
    tx_mode_next = tx_mode;
    if (q_head.is_symbol) begin
      if (accept_sym) begin
        if (q_head.marks != '0) begin
          tx_mode_next = MODE_MARK;
        end else begin
          tx_mode_next = (q_head.space == '0) ? MODE_IDLE : MODE_SPACE;
        end
      end
    end else begin
      unique case (tx_mode)
        MODE_MARK: begin
          if (wrap && marks_dec == '0) begin
            tx_mode_next = (pending_space == '0) ? MODE_IDLE : MODE_SPACE;
          end
        end
        MODE_SPACE: begin
          if (space_dec == '0) begin
            tx_mode_next = MODE_IDLE;
          end
        end
        default: tx_mode_next = tx_mode;
      endcase
    end
  end

  // Datapath next values.
  always_comb begin
    phase_acc_next     = phase_acc;
    marks_left_next    = marks_left;
    space_left_next    = space_left;
    pending_space_next = pending_space;
    if (q_head.is_symbol) begin
      if (accept_sym) begin
        marks_left_next    = q_head.marks;
        pending_space_next = q_head.space;
        phase_acc_next     = PHASE_HALF;
        if (q_head.marks == '0) begin
          space_left_next = q_head.space;
        end
      end
    end else if (tx_mode == MODE_MARK) begin
      if (wrap) begin
        phase_acc_next  = phase_sum - {1'b0, period_q};
        marks_left_next = marks_dec;
        if (marks_dec == '0) begin
          space_left_next = pending_space;
        end
      end else begin
        phase_acc_next = phase_sum;
      end
    end else if (tx_mode == MODE_SPACE) begin
      space_left_next = space_dec;
    end
  end

  // Result of this word, seen from the state it leaves behind.
  always_comb begin
    res_next.ir_level = (tx_mode_next == MODE_MARK) &&
                        ({phase_acc_next, 1'b0} < {2'b00, period_q});
    res_next.busy_res = (tx_mode_next == MODE_MARK) || (tx_mode_next == MODE_SPACE);
    res_next.rejected = q_head.is_symbol && busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode       <= MODE_IDLE;
      phase_acc     <= '0;
      marks_left    <= '0;
      space_left    <= '0;
      pending_space <= '0;
      res_valid     <= 1'b0;
    end else if (q_pop) begin
      tx_mode       <= tx_mode_next;
      phase_acc     <= phase_acc_next;
      marks_left    <= marks_left_next;
      space_left    <= space_left_next;
      pending_space <= pending_space_next;
      res_valid     <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/core/irpdt_checker.sv @@
// ----------------------------------------------------------------------------
// irpdt_checker
// Port-level checks of the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module irpdt_checker (
  input logic               clk,
  input logic               rst,
  input irpdt_pkg::result_t res,
  input logic               res_valid,
  input logic               res_stall
);
  import irpdt_pkg::*;

  // A refused symbol leaves the block busy.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> res.busy_res)
    else $error("rejected result without busy");

  // The emitter only fires while the block is busy.
  a_level_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ir_level |-> res.busy_res)
    else $error("emitter on while idle");

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

endmodule

bind ir_pulse_distance_transmitter_unit irpdt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res       (res),
  .res_valid (res_valid),
  .res_stall (res_stall)
);
